>>> rtl/abrf_pkg.sv
// ----------------------------------------------------------------------------
// abrf_pkg: shared types and constants of the banked register file
// Holds the request and response transaction types, the mode codes, the
// request and status codes and the internal access descriptor.
// ----------------------------------------------------------------------------
package abrf_pkg;

	// Request codes
	localparam logic [1:0] REQ_READ_REG   = 2'd0;
	localparam logic [1:0] REQ_WRITE_REG  = 2'd1;
	localparam logic [1:0] REQ_READ_SPSR  = 2'd2;
	localparam logic [1:0] REQ_WRITE_SPSR = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_MODE = 2'd1;
	localparam logic [1:0] ST_NO_SPSR  = 2'd2;

	// Processor mode codes
	localparam logic [4:0] MODE_USR = 5'b10000;
	localparam logic [4:0] MODE_FIQ = 5'b10001;
	localparam logic [4:0] MODE_IRQ = 5'b10010;
	localparam logic [4:0] MODE_SVC = 5'b10011;
	localparam logic [4:0] MODE_ABT = 5'b10111;
	localparam logic [4:0] MODE_UND = 5'b11011;
	localparam logic [4:0] MODE_SYS = 5'b11111;

	// Register indexes with special meaning
	localparam logic [3:0] IDX_FIQ_FIRST = 4'd8;
	localparam logic [3:0] IDX_SP        = 4'd13;
	localparam logic [3:0] IDX_LR        = 4'd14;
	localparam logic [3:0] IDX_PC        = 4'd15;

	// Store depths
	localparam int COMMON_DEPTH = 16;
	localparam int FIQ_DEPTH    = 7;
	localparam int BANK_DEPTH   = 8;
	localparam int SPSR_DEPTH   = 5;

	localparam int WORD_W = 32;

	// Request transaction
	typedef struct packed {
		logic [1:0]        req_type;
		logic [4:0]        cpu_mode;
		logic [3:0]        reg_index;
		logic [WORD_W-1:0] write_data;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [1:0]        status;
	} rsp_t;

	// Bank slot of a mode; the order matches the saved status store.
	typedef enum logic [2:0] {
		SLOT_FIQ  = 3'd0,
		SLOT_SVC  = 3'd1,
		SLOT_ABT  = 3'd2,
		SLOT_IRQ  = 3'd3,
		SLOT_UND  = 3'd4,
		SLOT_USER = 3'd5,
		SLOT_BAD  = 3'd6
	} slot_t;

	// Physical store that an access lands in
	typedef enum logic [2:0] {
		TGT_NONE,
		TGT_COMMON,
		TGT_FIQ,
		TGT_BANK,
		TGT_SPSR
	} target_t;

	// Decoded access handed from the decoder to the stores
	typedef struct packed {
		target_t    target;
		logic [3:0] addr;
		logic       wr;
		logic [1:0] status;
	} access_t;

endpackage

>>> rtl/abrf_decode.sv
// ----------------------------------------------------------------------------
// abrf_decode: mode and index decoder
// Maps a request onto one physical register or saved status word, or onto
// an error status when the mode has no such store.
// ----------------------------------------------------------------------------
module abrf_decode (
	input  abrf_pkg::req_t    req,
	output abrf_pkg::access_t acc
);
	import abrf_pkg::*;

	slot_t      slot;
	logic [2:0] slot_m1;

	// Mode code to bank slot.
	always_comb begin
		case (req.cpu_mode)
			MODE_FIQ: slot = SLOT_FIQ;
			MODE_SVC: slot = SLOT_SVC;
			MODE_ABT: slot = SLOT_ABT;
			MODE_IRQ: slot = SLOT_IRQ;
			MODE_UND: slot = SLOT_UND;
			MODE_USR: slot = SLOT_USER;
			MODE_SYS: slot = SLOT_USER;
			default:  slot = SLOT_BAD;
		endcase
	end

	// Pair number in the sp/lr bank: svc 0, abt 1, irq 2, und 3.
	assign slot_m1 = slot - 3'd1;

	// Select the target store and the address within it.
	always_comb begin
		acc.target = TGT_NONE;
		acc.addr   = 4'd0;
		acc.wr     = (req.req_type == REQ_WRITE_REG) || (req.req_type == REQ_WRITE_SPSR);
		acc.status = ST_OK;
		if (slot == SLOT_BAD) begin
			acc.status = ST_BAD_MODE;
		end else if ((req.req_type == REQ_READ_REG) || (req.req_type == REQ_WRITE_REG)) begin
			if ((req.reg_index == IDX_PC) || (slot == SLOT_USER)) begin
				acc.target = TGT_COMMON;
				acc.addr   = req.reg_index;
			end else if (slot == SLOT_FIQ) begin
				if (req.reg_index >= IDX_FIQ_FIRST) begin
					// FIQ r8 to r14 land at 0 to 6.
					acc.target = TGT_FIQ;
					acc.addr   = {1'b0, req.reg_index[2:0]};
				end else begin
					acc.target = TGT_COMMON;
					acc.addr   = req.reg_index;
				end
			end else if (req.reg_index >= IDX_SP) begin
				acc.target = TGT_BANK;
				acc.addr   = {1'b0, slot_m1[1:0], req.reg_index == IDX_LR};
			end else begin
				acc.target = TGT_COMMON;
				acc.addr   = req.reg_index;
			end
		end else if (slot == SLOT_USER) begin
			// User and system modes have no saved status.
			acc.status = ST_NO_SPSR;
		end else begin
			acc.target = TGT_SPSR;
			acc.addr   = {1'b0, slot};
		end
	end

endmodule

>>> rtl/abrf_regs.sv
// ----------------------------------------------------------------------------
// abrf_regs: physical register stores
// Common, FIQ, sp/lr and saved status registers, all cleared at reset.
// One decoded access is read or written per cycle.
// ----------------------------------------------------------------------------
module abrf_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  abrf_pkg::access_t             acc,
	input  logic [abrf_pkg::WORD_W-1:0]   write_data,
	output logic [abrf_pkg::WORD_W-1:0]   read_data
);
	import abrf_pkg::*;

	logic [WORD_W-1:0] common_q [COMMON_DEPTH];
	logic [WORD_W-1:0] fiq_q    [FIQ_DEPTH];
	logic [WORD_W-1:0] bank_q   [BANK_DEPTH];
	logic [WORD_W-1:0] spsr_q   [SPSR_DEPTH];

	logic wr_en;

	assign wr_en = en && acc.wr;

	// Write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMMON_DEPTH; i++) common_q[i] <= '0;
			for (int i = 0; i < FIQ_DEPTH; i++)    fiq_q[i]    <= '0;
			for (int i = 0; i < BANK_DEPTH; i++)   bank_q[i]   <= '0;
			for (int i = 0; i < SPSR_DEPTH; i++)   spsr_q[i]   <= '0;
		end else if (wr_en) begin
			case (acc.target)
				TGT_COMMON: common_q[acc.addr]     <= write_data;
				TGT_FIQ:    fiq_q[acc.addr[2:0]]   <= write_data;
				TGT_BANK:   bank_q[acc.addr[2:0]]  <= write_data;
				TGT_SPSR:   spsr_q[acc.addr[2:0]]  <= write_data;
				default: ;
			endcase
		end
	end

	// Read port; writes and refused requests return zero.
	always_comb begin
		read_data = '0;
		if (!acc.wr) begin
			case (acc.target)
				TGT_COMMON: read_data = common_q[acc.addr];
				TGT_FIQ:    read_data = fiq_q[acc.addr[2:0]];
				TGT_BANK:   read_data = bank_q[acc.addr[2:0]];
				TGT_SPSR:   read_data = spsr_q[acc.addr[2:0]];
				default:    read_data = '0;
			endcase
		end
	end

endmodule

>>> rtl/arm_banked_register_file.sv
// ----------------------------------------------------------------------------
// arm_banked_register_file: ARMv4 banked register file
// Request register, mode decoder, register stores and response register.
// ----------------------------------------------------------------------------
// Each transaction is one access to a register or to a saved status word of
// the named processor mode and yields exactly one response. The block takes
// one request per cycle while in_stall is low. Each request is held in the
// request register in front of the decode and store access, and its response
// is held in the response register behind it. A write takes effect when its
// request leaves the request register, so the next request already sees it.
// While the response register holds an untaken response the request register
// stalls, and the input stalls once that register is full as well.
module arm_banked_register_file (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  abrf_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output abrf_pkg::rsp_t out_data
);
	import abrf_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	logic              out_free;
	logic              advance;
	access_t           acc;
	logic [WORD_W-1:0] rdata;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	abrf_decode u_decode (
		.req (req_s1),
		.acc (acc)
	);

	abrf_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.acc        (acc),
		.write_data (req_s1.write_data),
		.read_data  (rdata)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.read_data <= rdata;
			out_data.status    <= acc.status;
		end
	end

	// A refused request never returns data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> out_data.read_data == '0)
		else $error("refused request returned nonzero data");

	// The input stalls only behind a held request.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held request");

	// A request that leaves the request register shows up as a response.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced request produced no response");

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_BAD_MODE)
			|| (out_data.status == ST_NO_SPSR))
		else $error("undefined status code");

endmodule
